### hdl/jsqd_pkg.sv
// ----------------------------------------------------------------------------
// jsqd_pkg
// Shared types and constants for the shortest-queue frame dispatcher.
// ----------------------------------------------------------------------------
package jsqd_pkg;

  localparam int MAX_OUTPUTS = 16;
  localparam int MAX_DEPTH   = 1023;

  localparam int OP_W     = 2;
  localparam int IDX_W    = $clog2(MAX_OUTPUTS);
  localparam int DEPTH_W  = 10;
  localparam int CNT_W    = 5;
  localparam int ENA_W    = 16;
  localparam int NUM_W    = 16;
  localparam int STAT_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int BIT_CNT_W  = $clog2(NUM_W);

  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_OUTPUTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ENABLE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT    = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_GO    = 2'd0,
    OP_FRAME = 2'd1,
    OP_DEPTH = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DISPATCHED = 3'd0,
    STAT_DROPPED    = 3'd1,
    STAT_WAITING    = 3'd2,
    STAT_FINISHED   = 3'd3,
    STAT_ACCEPTED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MOD,
    S_SCAN,
    S_COMMIT,
    S_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic decode;
    logic mod_step;
    logic scan_step;
    logic commit;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_send;
    logic cnt_zero;
    logic mod_last;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

### hdl/jsqd_if.sv
// ----------------------------------------------------------------------------
// jsqd_in_if / jsqd_out_if
// Valid/ready channels for requests into and results out of the dispatcher.
// ----------------------------------------------------------------------------
interface jsqd_in_if import jsqd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [IDX_W-1:0]   queue_index;
  logic [DEPTH_W-1:0] queue_depth;

  modport source(output valid, output operation, output queue_index,
                 output queue_depth, input ready);
  modport sink(input valid, input operation, input queue_index,
               input queue_depth, output ready);
endinterface

interface jsqd_out_if import jsqd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  target_output;
  logic [NUM_W-1:0]  frame_number;
  logic              finished;

  modport source(output valid, output status, output target_output,
                 output frame_number, output finished, input ready);
  modport sink(input valid, input status, input target_output,
               input frame_number, input finished, output ready);
endinterface

### hdl/jsqd_ctrl.sv
// ----------------------------------------------------------------------------
// jsqd_ctrl
// Sequencer: takes one request, runs the modulo and scan phases when a frame
// is sent, then hands the result to the output register.
// ----------------------------------------------------------------------------
module jsqd_ctrl import jsqd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (!stat.need_send)    state_next = S_RESULT;
        else if (stat.cnt_zero) state_next = S_COMMIT;
        else                    state_next = S_MOD;
      end
      S_MOD: begin
        if (stat.mod_last) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_last) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DECODE: cmd.decode    = 1'b1;
      S_MOD:    cmd.mod_step  = 1'b1;
      S_SCAN:   cmd.scan_step = 1'b1;
      S_COMMIT: cmd.commit    = 1'b1;
      S_RESULT: cmd.load_out  = stat.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hdl/jsqd_dp.sv
// ----------------------------------------------------------------------------
// jsqd_dp
// Datapath: configuration, credit and depth state, serial modulo, depth
// scan and the output register.
// ----------------------------------------------------------------------------
module jsqd_dp import jsqd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [IDX_W-1:0]      in_queue_index,
  input  logic [DEPTH_W-1:0]    in_queue_depth,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STAT_W-1:0]     out_status,
  output logic [IDX_W-1:0]      out_target_output,
  output logic [NUM_W-1:0]      out_frame_number,
  output logic                  out_finished,
  input  cmd_t                  cmd,
  output stat_t                 stat
);

  // Configuration registers.
  logic              manual_mode;
  logic [CNT_W-1:0]  active_outputs;
  logic [ENA_W-1:0]  output_enable;
  logic [NUM_W-1:0]  frame_limit;

  // Dispatcher state.
  logic [NUM_W-1:0]   go_credits;
  logic [NUM_W-1:0]   waiting_frames;
  logic [NUM_W-1:0]   frame_counter;
  logic [DEPTH_W-1:0] queue_depths [MAX_OUTPUTS];
  logic               done_flag;

  // Captured request.
  logic [OP_W-1:0]    op_q;
  logic [IDX_W-1:0]   qi_q;
  logic [DEPTH_W-1:0] qd_q;

  // Modulo and scan working registers.
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [IDX_W-1:0]     scan_idx;
  logic [IDX_W-1:0]     scan_cnt;
  logic                 found;
  logic [IDX_W-1:0]     best;
  logic [DEPTH_W-1:0]   best_depth;

  // Result waiting for the output register.
  status_t            res_status;
  logic [IDX_W-1:0]   res_target;
  logic [NUM_W-1:0]   res_number;
  logic               res_finished;

  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   mod_shift;
  logic [CNT_W-1:0]   mod_sub;
  logic [CNT_W-1:0]   idx_inc;
  logic [DEPTH_W-1:0] cur_depth;
  logic               take;
  logic [NUM_W-1:0]   fc_inc;
  logic               done_next;
  logic               need_send;

  assign cnt = (active_outputs > CNT_W'(MAX_OUTPUTS)) ? CNT_W'(MAX_OUTPUTS)
                                                      : active_outputs;

  // One restoring step of frame_counter modulo cnt, most significant bit first.
  assign mod_shift = {scan_idx, frame_counter[~bit_cnt]};
  assign mod_sub   = (mod_shift >= cnt) ? (mod_shift - cnt) : mod_shift;

  assign idx_inc   = {1'b0, scan_idx} + CNT_W'(1);
  assign cur_depth = queue_depths[scan_idx];
  assign take      = output_enable[scan_idx] && (!found || (cur_depth < best_depth));

  assign fc_inc    = frame_counter + NUM_W'(1);
  assign done_next = (frame_limit != '0) && (fc_inc == frame_limit);

  always_comb begin
    need_send = 1'b0;
    if (!done_flag) begin
      case (op_q)
        OP_GO:    need_send = (waiting_frames != '0);
        OP_FRAME: need_send = !manual_mode || (go_credits != '0);
        default:  need_send = 1'b0;
      endcase
    end
  end

  assign stat.need_send = need_send;
  assign stat.cnt_zero  = (cnt == '0);
  assign stat.mod_last  = (bit_cnt == '1);
  assign stat.scan_last = ({1'b0, scan_cnt} == (cnt - CNT_W'(1)));
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      manual_mode    <= 1'b1;
      active_outputs <= CNT_W'(1);
      output_enable  <= ENA_W'(1);
      frame_limit    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MANUAL_MODE:    manual_mode    <= cfg_data[0];
        CFG_ACTIVE_OUTPUTS: active_outputs <= cfg_data[CNT_W-1:0];
        CFG_OUTPUT_ENABLE:  output_enable  <= cfg_data[ENA_W-1:0];
        CFG_FRAME_LIMIT:    frame_limit    <= cfg_data[NUM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= in_operation;
      qi_q <= in_queue_index;
      qd_q <= in_queue_depth;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      go_credits     <= '0;
      waiting_frames <= '0;
      frame_counter  <= '0;
      done_flag      <= 1'b0;
      for (int k = 0; k < MAX_OUTPUTS; k++) begin
        queue_depths[k] <= '0;
      end
    end else if (cmd.decode && !done_flag) begin
      case (op_q)
        OP_GO: begin
          if (waiting_frames != '0)  waiting_frames <= waiting_frames - NUM_W'(1);
          else if (go_credits != '1) go_credits     <= go_credits + NUM_W'(1);
        end
        OP_FRAME: begin
          if (manual_mode) begin
            if (go_credits != '0)          go_credits     <= go_credits - NUM_W'(1);
            else if (waiting_frames != '1) waiting_frames <= waiting_frames + NUM_W'(1);
          end
        end
        OP_DEPTH: begin
          queue_depths[qi_q] <= (qd_q > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : qd_q;
        end
        default: begin
        end
      endcase
    end else if (cmd.commit) begin
      if (found && (best_depth < DEPTH_W'(MAX_DEPTH))) begin
        queue_depths[best] <= best_depth + DEPTH_W'(1);
      end
      frame_counter <= fc_inc;
      if (done_next) done_flag <= 1'b1;
    end
  end

  // Modulo and scan share scan_idx: the remainder becomes the first index.
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      bit_cnt  <= '0;
      scan_idx <= '0;
      scan_cnt <= '0;
      found    <= 1'b0;
    end else if (cmd.mod_step) begin
      bit_cnt  <= bit_cnt + BIT_CNT_W'(1);
      scan_idx <= mod_sub[IDX_W-1:0];
    end else if (cmd.scan_step) begin
      scan_cnt <= scan_cnt + IDX_W'(1);
      scan_idx <= (idx_inc == cnt) ? '0 : idx_inc[IDX_W-1:0];
      if (take) begin
        found      <= 1'b1;
        best       <= scan_idx;
        best_depth <= cur_depth;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      res_target   <= '0;
      res_number   <= frame_counter;
      res_finished <= done_flag;
      if (done_flag) begin
        res_status <= STAT_FINISHED;
      end else if ((op_q == OP_FRAME) && manual_mode && (go_credits == '0)) begin
        res_status <= STAT_WAITING;
      end else begin
        res_status <= STAT_ACCEPTED;
      end
    end else if (cmd.commit) begin
      res_status   <= found ? STAT_DISPATCHED : STAT_DROPPED;
      res_target   <= found ? best : '0;
      res_number   <= frame_counter;
      res_finished <= done_flag || done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status        <= res_status;
      out_target_output <= res_target;
      out_frame_number  <= res_number;
      out_finished      <= res_finished;
    end
  end

endmodule

### hdl/credit_gated_shortest_queue_dispatcher.sv
// ----------------------------------------------------------------------------
// credit_gated_shortest_queue_dispatcher
// Routes each frame to the enabled output with the fewest queued frames,
// gated by go credits in manual mode.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake        Payload
// in_ch     in         valid/ready      operation, queue_index, queue_depth
// out_ch    out        valid/ready      status, target_output, frame_number,
//                                       finished
// cfg       in         cfg_write only   cfg_index, cfg_data
//
// One request at a time. A request that sends a frame runs a serial modulo
// of the frame counter for the rotating start, then scans one stored depth
// per cycle over the N active outputs; with no active output the modulo and
// scan are skipped. Other requests go straight from decode to the result.
// Synchronous active-high reset clears the credit, waiting and frame counters and depth copies.
// A full output register stalls the result; the next request is accepted
// once the current result has moved into the output register.
// ----------------------------------------------------------------------------
module credit_gated_shortest_queue_dispatcher import jsqd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  jsqd_in_if.sink               in_ch,
  jsqd_out_if.source            out_ch,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  jsqd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  jsqd_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_operation      (in_ch.operation),
    .in_queue_index    (in_ch.queue_index),
    .in_queue_depth    (in_ch.queue_depth),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_target_output (out_ch.target_output),
    .out_frame_number  (out_ch.frame_number),
    .out_finished      (out_ch.finished),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

### hdl/jsqd_chk.sv
// ----------------------------------------------------------------------------
// jsqd_chk
// Port-level checks on the dispatcher's result channel.
// ----------------------------------------------------------------------------
module jsqd_chk import jsqd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] status,
  input logic [IDX_W-1:0]  target_output,
  input logic [NUM_W-1:0]  frame_number,
  input logic              finished
);

  logic out_fire;
  assign out_fire = out_valid && out_ready;

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(status) && $stable(target_output) &&
                                $stable(frame_number) && $stable(finished))
    else $error("result payload changed while stalled");

  a_target_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STAT_DISPATCHED) |-> (target_output == '0))
    else $error("target set on a result that dispatched nothing");

  a_finished_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_FINISHED) |-> finished)
    else $error("finished status without finished flag");

  a_finished_sticky: assert property (@(posedge clk) disable iff (rst)
    out_fire && finished |=> !out_valid || finished)
    else $error("finished flag cleared after the run ended");

endmodule

bind credit_gated_shortest_queue_dispatcher jsqd_chk u_jsqd_chk (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .target_output (out_ch.target_output),
  .frame_number  (out_ch.frame_number),
  .finished      (out_ch.finished)
);

### verif/credit_gated_shortest_queue_dispatcher_test.sv
// ----------------------------------------------------------------------------
// credit_gated_shortest_queue_dispatcher_test
// Self-checking bench for the shortest-queue frame dispatcher. A local copy of
// the routing rules predicts every result and compares each returned result
// with it, while the request and result channels idle and stall at random.
// ----------------------------------------------------------------------------
module credit_gated_shortest_queue_dispatcher_test;
  import jsqd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 48;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 62;
  localparam int PILEUP_GOS    = 40;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_THIRD,
    SINK_LONG
  } sink_mode_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] target;
    logic [NUM_W-1:0] number;
    logic             finished;
  } dispatch_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  jsqd_in_if  in_ch();
  jsqd_out_if out_ch();

  credit_gated_shortest_queue_dispatcher u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Local copy of the dispatcher's registers and state.
  logic               manual_mode;
  logic [CNT_W-1:0]   active_count;
  logic [ENA_W-1:0]   enable_mask;
  logic [NUM_W-1:0]   frame_limit;
  logic [15:0]        go_credit_count;
  logic [15:0]        waiting_frames;
  logic [NUM_W-1:0]   frame_count;
  logic [DEPTH_W-1:0] depth_copy [MAX_OUTPUTS];
  logic               limit_reached;

  dispatch_result_t predicted_results [$];
  dispatch_result_t oldest_result;

  int mismatch_count;
  int requests_sent;
  int results_checked;
  int frames_dispatched;
  int frames_dropped;
  int frames_held;
  int settings_count;
  int cycle_count;
  int burst_left;
  int sink_tick;
  bit steady_source;
  bit steady_sink;
  sink_mode_t sink_mode;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, predicted_results.size());
      $display("credit_gated_shortest_queue_dispatcher test failed");
      $finish;
    end
  end

  // Result side: a stall pattern picked at random from four sink modes.
  always @(negedge clk) begin
    sink_tick++;
    if (rst || steady_sink) begin
      out_ch.ready <= 1'b1;
    end else begin
      case (sink_mode)
        SINK_OPEN:   out_ch.ready <= 1'b1;
        SINK_RANDOM: out_ch.ready <= 1'($urandom_range(1));
        SINK_THIRD:  out_ch.ready <= (sink_tick % 3) != 0;
        default:     out_ch.ready <= (sink_tick % 16) >= 12;
      endcase
    end
    if (sink_tick % 128 == 0) begin
      sink_mode = sink_mode_t'($urandom_range(3));
    end
  end

  task automatic report_mismatch(input string field, input logic [NUM_W-1:0] got,
                                 input logic [NUM_W-1:0] want);
    if (mismatch_count < 40) begin
      $display("Mismatch on result %0d at cycle %0d: %s is %0d, expected %0d",
               results_checked, cycle_count, field, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("unrequested result, status", NUM_W'(out_ch.status), '0);
      end else begin
        oldest_result = predicted_results.pop_front();
        if (out_ch.status !== oldest_result.status) begin
          report_mismatch("status", NUM_W'(out_ch.status), NUM_W'(oldest_result.status));
        end
        if (out_ch.target_output !== oldest_result.target) begin
          report_mismatch("target_output", NUM_W'(out_ch.target_output),
                          NUM_W'(oldest_result.target));
        end
        if (out_ch.frame_number !== oldest_result.number) begin
          report_mismatch("frame_number", out_ch.frame_number, oldest_result.number);
        end
        if (out_ch.finished !== oldest_result.finished) begin
          report_mismatch("finished", NUM_W'(out_ch.finished), NUM_W'(oldest_result.finished));
        end
        case (oldest_result.status)
          STAT_DISPATCHED: frames_dispatched++;
          STAT_DROPPED:    frames_dropped++;
          STAT_WAITING:    frames_held++;
          default: ;
        endcase
      end
      results_checked++;
    end
  end

  // Picks the least occupied enabled output, scanning from the rotating start.
  function automatic dispatch_result_t route_frame();
    dispatch_result_t r;
    int count;
    int start;
    int i;
    int j;
    int best;
    bit found;
    count = (active_count > MAX_OUTPUTS) ? MAX_OUTPUTS : int'(active_count);
    found = 1'b0;
    best = 0;
    r.number = frame_count;
    r.target = '0;
    r.finished = 1'b0;
    if (count > 0) begin
      start = frame_count % count;
      for (i = 0; i < count; i++) begin
        j = (start + i) % count;
        if (enable_mask[j] && (!found || depth_copy[j] < depth_copy[best])) begin
          found = 1'b1;
          best = j;
        end
      end
    end
    if (found && depth_copy[best] < MAX_DEPTH) begin
      depth_copy[best] = depth_copy[best] + 1'b1;
    end
    frame_count = frame_count + 1'b1;
    if (frame_limit != 0 && frame_count == frame_limit) begin
      limit_reached = 1'b1;
    end
    r.status = found ? STAT_DISPATCHED : STAT_DROPPED;
    if (found) begin
      r.target = IDX_W'(best);
    end
    return r;
  endfunction

  function automatic dispatch_result_t dispatch_outcome(input logic [OP_W-1:0] op,
                                                        input logic [IDX_W-1:0] idx,
                                                        input logic [DEPTH_W-1:0] depth);
    dispatch_result_t r;
    r.status = STAT_ACCEPTED;
    r.target = '0;
    r.number = frame_count;
    r.finished = 1'b0;
    if (limit_reached) begin
      r.status = STAT_FINISHED;
    end else begin
      case (op)
        OP_GO: begin
          if (waiting_frames != 0) begin
            waiting_frames = waiting_frames - 1'b1;
            r = route_frame();
          end else if (go_credit_count != 16'hFFFF) begin
            go_credit_count = go_credit_count + 1'b1;
          end
        end
        OP_FRAME: begin
          if (!manual_mode) begin
            r = route_frame();
          end else if (go_credit_count != 0) begin
            go_credit_count = go_credit_count - 1'b1;
            r = route_frame();
          end else begin
            if (waiting_frames != 16'hFFFF) begin
              waiting_frames = waiting_frames + 1'b1;
            end
            r.status = STAT_WAITING;
          end
        end
        OP_DEPTH: begin
          depth_copy[idx] = (depth > MAX_DEPTH) ? DEPTH_W'(MAX_DEPTH) : depth;
        end
        default: ;
      endcase
    end
    r.finished = limit_reached;
    return r;
  endfunction

  // Requests go out in bursts; valid stays high from one request to the next.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic [DEPTH_W-1:0] depth);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = (steady_source || $urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.queue_index <= idx;
    in_ch.queue_depth <= depth;
    do @(posedge clk); while (!in_ch.ready);
    predicted_results.insert(predicted_results.size(), dispatch_outcome(op, idx, depth));
    requests_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (predicted_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    case (index)
      CFG_MANUAL_MODE:    manual_mode  = data[0];
      CFG_ACTIVE_OUTPUTS: active_count = data[CNT_W-1:0];
      CFG_OUTPUT_ENABLE:  enable_mask  = data[ENA_W-1:0];
      CFG_FRAME_LIMIT:    frame_limit  = data[NUM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic manual, input logic [CNT_W-1:0] count,
                            input logic [ENA_W-1:0] mask, input logic [NUM_W-1:0] lim);
    drain_results();
    write_reg(CFG_MANUAL_MODE, CFG_DATA_W'(manual));
    write_reg(CFG_ACTIVE_OUTPUTS, CFG_DATA_W'(count));
    write_reg(CFG_OUTPUT_ENABLE, CFG_DATA_W'(mask));
    write_reg(CFG_FRAME_LIMIT, CFG_DATA_W'(lim));
    settings_count++;
  endtask

  // Starts from the reset settings: manual mode, one active output.
  task automatic test_credit_gating();
    send_request(OP_FRAME, '0, '0);
    send_request(OP_FRAME, '1, '1);
    send_request(OP_GO, '0, '0);
    send_request(OP_GO, '0, '0);
    send_request(OP_GO, '0, '0);
    send_request(OP_FRAME, '0, '0);
    send_request(OP_RESERVED, '1, '1);
    send_request(OP_FRAME, '0, '0);
    // A go credit still releases a held frame after leaving manual mode.
    set_config(1'b0, 5'd1, 16'h0001, '0);
    send_request(OP_GO, '0, '0);
    send_request(OP_FRAME, '0, '0);
  endtask

  task automatic test_depth_reports();
    set_config(1'b0, 5'd4, 16'h000F, '0);
    send_request(OP_DEPTH, 4'd0, DEPTH_W'(MAX_DEPTH));
    send_request(OP_DEPTH, 4'd1, 10'd5);
    send_request(OP_DEPTH, 4'd2, 10'd5);
    send_request(OP_DEPTH, 4'd3, DEPTH_W'(MAX_DEPTH));
    send_request(OP_DEPTH, 4'd15, 10'd0);
    send_request(OP_FRAME, '0, '0);
    send_request(OP_FRAME, '0, '0);
    send_request(OP_FRAME, '0, '0);
  endtask

  task automatic test_output_selection();
    set_config(1'b0, 5'd0, 16'hFFFF, '0);
    send_request(OP_FRAME, '0, '0);
    set_config(1'b0, 5'd16, 16'h0000, '0);
    send_request(OP_FRAME, '0, '0);
    // Counts above sixteen behave as sixteen.
    set_config(1'b0, 5'd31, 16'h8000, '0);
    send_request(OP_FRAME, '0, '0);
    set_config(1'b0, 5'd17, 16'h0001, '0);
    send_request(OP_FRAME, '0, '0);
    set_config(1'b0, 5'd1, 16'hFFFE, '0);
    send_request(OP_FRAME, '0, '0);
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    int pick;
    logic [CNT_W-1:0]   count;
    logic [ENA_W-1:0]   mask;
    logic [NUM_W-1:0]   lim;
    logic [DEPTH_W-1:0] depth;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick = $urandom_range(9);
      count = (pick == 0) ? 5'd0 : (pick == 1) ? CNT_W'($urandom_range(31, 17))
                                               : CNT_W'($urandom_range(16, 1));
      pick = $urandom_range(15);
      mask = (pick < 4) ? 16'hFFFF : (pick == 4) ? 16'h0000
           : (pick < 8) ? ENA_W'(1 << $urandom_range(15)) : ENA_W'($urandom);
      // Limits here are either unreachable or already behind the counter.
      pick = $urandom_range(3);
      lim = (phase == 0 || pick == 0) ? 16'hFFFF
          : (pick == 1) ? NUM_W'($urandom_range(frame_count)) : '0;
      set_config(1'($urandom_range(1)), count, mask, lim);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        case ($urandom_range(3))
          0:       depth = $urandom_range(1) ? DEPTH_W'(MAX_DEPTH) : '0;
          3:       depth = DEPTH_W'($urandom);
          default: depth = DEPTH_W'($urandom_range(7));
        endcase
        if (pick < 40) begin
          send_request(OP_FRAME, IDX_W'($urandom), DEPTH_W'($urandom));
        end else if (pick < 65) begin
          send_request(OP_GO, IDX_W'($urandom), DEPTH_W'($urandom));
        end else if (pick < 95) begin
          send_request(OP_DEPTH, IDX_W'($urandom), depth);
        end else begin
          send_request(OP_RESERVED, IDX_W'($urandom), DEPTH_W'($urandom));
        end
      end
    end
  endtask

  // Go credits pile up with both channels running flat out, then frames
  // spend a few.
  task automatic test_credit_pileup();
    int n;
    set_config(1'b1, 5'd16, 16'hFFFF, '0);
    while (waiting_frames != 0) send_request(OP_GO, '0, '0);
    steady_source = 1'b1;
    steady_sink = 1'b1;
    for (n = 0; n < PILEUP_GOS; n++) begin
      send_request(OP_GO, IDX_W'($urandom), DEPTH_W'($urandom));
    end
    steady_source = 1'b0;
    steady_sink = 1'b0;
    send_request(OP_FRAME, '0, '0);
    send_request(OP_FRAME, '0, '0);
    send_request(OP_GO, '0, '0);
    send_request(OP_GO, '0, '0);
  endtask

  // Runs last: once the limit is hit every request answers finished for good.
  task automatic test_frame_limit();
    set_config(1'b0, 5'd16, 16'hFFFF, frame_count + 16'd3);
    send_request(OP_FRAME, '0, '0);
    send_request(OP_FRAME, '0, '0);
    send_request(OP_FRAME, '0, '0);
    send_request(OP_GO, '0, '0);
    send_request(OP_FRAME, '0, '0);
    send_request(OP_DEPTH, 4'd5, 10'd9);
    send_request(OP_RESERVED, '0, '0);
    set_config(1'b1, 5'd1, 16'h0001, '0);
    send_request(OP_FRAME, '0, '0);
    send_request(OP_GO, '0, '0);
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.queue_index = '0;
    in_ch.queue_depth = '0;
    out_ch.ready = 1'b0;
    sink_mode = SINK_OPEN;
    manual_mode = 1'b1;
    active_count = 5'd1;
    enable_mask = 16'h0001;
    frame_limit = '0;
    go_credit_count = '0;
    waiting_frames = '0;
    frame_count = '0;
    limit_reached = 1'b0;
    foreach (depth_copy[k]) depth_copy[k] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_credit_gating();
    test_depth_reports();
    test_output_selection();
    test_random_traffic();
    test_credit_pileup();
    test_frame_limit();

    drain_results();
    repeat (END_CYCLES) @(negedge clk);
    $display("Checked %0d results for %0d requests: %0d frames dispatched, %0d dropped, %0d held.",
             results_checked, requests_sent, frames_dispatched, frames_dropped, frames_held);
    $display("Covered credit gating, depth reports, %0d register settings, credit pile-up, frame limit.",
             settings_count);
    if (mismatch_count == 0) begin
      $display("credit_gated_shortest_queue_dispatcher test passed");
    end else begin
      $display("credit_gated_shortest_queue_dispatcher test failed");
    end
    $finish;
  end

endmodule
